### sv/fmpi_pkg.sv
package fmpi_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int OUT_W       = 48;
    localparam int CFG_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int FIFO_DEPTH  = 8;
    localparam int FIFO_AW     = 3;

    localparam logic [CFG_W-1:0] FIELD_COUNT_RST = 7'd2;
    localparam logic [CFG_W-1:0] EMBED_DIM_RST   = 7'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIELD_COUNT = 1'b0,
        CFG_EMBED_DIM   = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic first_row;
        logic last_row;
        logic last_col;
    } t_item_flags;

endpackage

### sv/fmpi_elem_if.sv
interface fmpi_elem_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [fmpi_pkg::SAMPLE_BITS-1:0]  element_value;

    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

### sv/fmpi_result_if.sv
interface fmpi_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [fmpi_pkg::OUT_W-1:0]  interaction;

    modport source (output valid, output interaction, input ready);
    modport sink   (input valid, input interaction, output ready);
endinterface

### sv/fm_pairwise_interaction_core.sv
// Channel   Port        Dir  Payload                      Transaction
// elements  i_elem      in   element_value  s16 Q4.12     valid & ready
// results   o_result    out  interaction    s48 Q24.24    valid & ready
// config    i_cfg_*     in   idx 0 field_count, 1 embed_dim   i_cfg_we
//
// One element per cycle while i_elem.ready is high; results pass r1, r2
// (column RAM), r3, r4 to the FIFO. Column sums live in a registered RAM
// read at accept and written back the next cycle, with a one-deep bypass.
// Reset is synchronous; the column RAMs are not cleared (row 0 overwrites).
// i_elem.ready drops only when the 8-entry result FIFO plus results in flight
// would overflow, i.e. after o_result.ready has been held low.
module fm_pairwise_interaction_core #(
    parameter int MAX_FIELDS = 64,
    parameter int MAX_DIM    = 64
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    fmpi_elem_if.sink                         i_elem,
    fmpi_result_if.source                     o_result,
    input  logic                              i_cfg_we,
    input  logic [fmpi_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fmpi_pkg::CFG_W-1:0]        i_cfg_data
);

    localparam int SB    = fmpi_pkg::SAMPLE_BITS;
    localparam int OW    = fmpi_pkg::OUT_W;
    localparam int CW    = fmpi_pkg::CFG_W;
    localparam int FAW   = fmpi_pkg::FIFO_AW;
    localparam int RW    = $clog2(MAX_FIELDS);
    localparam int CLW   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int SUMW  = SB + $clog2(MAX_FIELDS);
    localparam int SQW   = 2 * SB + $clog2(MAX_FIELDS);
    localparam int PW    = 2 * SUMW;
    localparam int DW    = (PW + 1 > OW + 1) ? PW + 1 : OW + 1;
    localparam int LWF   = (($clog2(MAX_FIELDS + 1) > CW) ? $clog2(MAX_FIELDS + 1) : CW) + 1;
    localparam int LWD   = (($clog2(MAX_DIM + 1) > CW) ? $clog2(MAX_DIM + 1) : CW) + 1;

    logic [CW-1:0]          r_field_count;
    logic [CW-1:0]          r_embed_dim;
    logic [RW-1:0]          r_row;
    logic [CLW-1:0]         r_col;
    logic [FAW:0]           r_pending;
    logic [OW-1:0]          r_total;

    logic                   r3_valid;
    logic signed [PW-1:0]   r3_prod;
    logic [SQW-1:0]         r3_sq;
    fmpi_pkg::t_item_flags  r3_flags;
    logic                   r4_valid;
    logic [OW-1:0]          r4_half;
    fmpi_pkg::t_item_flags  r4_flags;

    logic [LWF-1:0]         w_rows;
    logic [LWD-1:0]         w_cols;
    logic                   w_accept;
    fmpi_pkg::t_item_flags  w_flags;
    logic signed [2*SB-1:0] w_x_sq;
    logic [SQW-1:0]         w_sq_ext;
    logic                   w_m_valid;
    logic signed [SUMW-1:0] w_m_sum;
    logic [SQW-1:0]         w_m_sq;
    fmpi_pkg::t_item_flags  w_m_flags;
    logic signed [DW-1:0]   w_diff;
    logic [OW-1:0]          w_total_sum;
    logic                   w_push;
    logic [FAW:0]           w_fifo_count;
    logic                   w_result_item;

    always_comb begin
        if (r_field_count == '0) begin
            w_rows = LWF'(1);
        end else if (LWF'(r_field_count) > LWF'(MAX_FIELDS)) begin
            w_rows = LWF'(MAX_FIELDS);
        end else begin
            w_rows = LWF'(r_field_count);
        end
        if (r_embed_dim == '0) begin
            w_cols = LWD'(1);
        end else if (LWD'(r_embed_dim) > LWD'(MAX_DIM)) begin
            w_cols = LWD'(MAX_DIM);
        end else begin
            w_cols = LWD'(r_embed_dim);
        end
        w_flags.first_row = (r_row == '0);
        w_flags.last_row  = (LWF'(r_row) + LWF'(1) >= w_rows);
        w_flags.last_col  = (LWD'(r_col) + LWD'(1) >= w_cols);
    end

    assign w_result_item = w_flags.last_row && w_flags.last_col;
    assign i_elem.ready  = ((FAW+2)'(w_fifo_count) + (FAW+2)'(r_pending))
                           < (FAW+2)'(fmpi_pkg::FIFO_DEPTH);
    assign w_accept      = i_elem.valid && i_elem.ready;
    assign w_x_sq        = i_elem.element_value * i_elem.element_value;
    assign w_sq_ext      = {{(SQW-2*SB){1'b0}}, w_x_sq};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_field_count <= fmpi_pkg::FIELD_COUNT_RST;
            r_embed_dim   <= fmpi_pkg::EMBED_DIM_RST;
        end else if (i_cfg_we) begin
            unique case (fmpi_pkg::t_cfg_reg'(i_cfg_idx))
                fmpi_pkg::CFG_FIELD_COUNT: r_field_count <= i_cfg_data;
                fmpi_pkg::CFG_EMBED_DIM:   r_embed_dim   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
        end else if (w_accept) begin
            if (w_flags.last_col) begin
                r_col <= '0;
                r_row <= w_flags.last_row ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    fmpi_col_mem #(
        .DEPTH (MAX_DIM),
        .AW    (CLW),
        .SUMW  (SUMW),
        .SQW   (SQW)
    ) u_col_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_addr  (r_col),
        .i_x     (i_elem.element_value),
        .i_sq    (w_sq_ext),
        .i_flags (w_flags),
        .o_valid (w_m_valid),
        .o_sum   (w_m_sum),
        .o_sq    (w_m_sq),
        .o_flags (w_m_flags)
    );

    assign w_diff      = DW'(r3_prod) - DW'(r3_sq);
    assign w_total_sum = r_total + r4_half;
    assign w_push      = r4_valid && r4_flags.last_row && r4_flags.last_col;

    always_ff @(posedge i_clk) begin
        r3_prod  <= w_m_sum * w_m_sum;
        r3_sq    <= w_m_sq;
        r3_flags <= w_m_flags;
        r4_half  <= w_diff[OW:1];
        r4_flags <= r3_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid  <= 1'b0;
            r4_valid  <= 1'b0;
            r_total   <= '0;
            r_pending <= '0;
        end else begin
            r3_valid  <= w_m_valid;
            r4_valid  <= r3_valid;
            r_pending <= r_pending + {{FAW{1'b0}}, w_accept && w_result_item}
                         - {{FAW{1'b0}}, w_push};
            if (r4_valid && r4_flags.last_row) begin
                r_total <= r4_flags.last_col ? '0 : w_total_sum;
            end
        end
    end

    fmpi_out_fifo u_out_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_total_sum),
        .o_count  (w_fifo_count),
        .o_result (o_result)
    );

endmodule

### sv/fmpi_col_mem.sv
module fmpi_col_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int SUMW  = 22,
    parameter int SQW   = 38
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    input  logic [AW-1:0]                          i_addr,
    input  logic signed [fmpi_pkg::SAMPLE_BITS-1:0] i_x,
    input  logic [SQW-1:0]                         i_sq,
    input  fmpi_pkg::t_item_flags                  i_flags,
    output logic                                   o_valid,
    output logic signed [SUMW-1:0]                 o_sum,
    output logic [SQW-1:0]                         o_sq,
    output fmpi_pkg::t_item_flags                  o_flags
);

    localparam int SB = fmpi_pkg::SAMPLE_BITS;

    logic signed [SUMW-1:0] mem_sum [DEPTH];
    logic [SQW-1:0]         mem_sq  [DEPTH];

    logic                   r1_valid;
    logic [AW-1:0]          r1_addr;
    logic signed [SB-1:0]   r1_x;
    logic [SQW-1:0]         r1_sq;
    fmpi_pkg::t_item_flags  r1_flags;
    logic signed [SUMW-1:0] r_rd_sum;
    logic [SQW-1:0]         r_rd_sq;
    logic                   r_fwd_hit;
    logic signed [SUMW-1:0] r_fwd_sum;
    logic [SQW-1:0]         r_fwd_sq;
    logic                   r2_valid;
    logic signed [SUMW-1:0] r2_sum;
    logic [SQW-1:0]         r2_sq;
    fmpi_pkg::t_item_flags  r2_flags;

    logic signed [SUMW-1:0] w_x_ext;
    logic signed [SUMW-1:0] w_base_sum;
    logic [SQW-1:0]         w_base_sq;
    logic signed [SUMW-1:0] n_sum;
    logic [SQW-1:0]         n_sq;

    always_comb begin
        w_x_ext    = {{(SUMW-SB){r1_x[SB-1]}}, r1_x};
        w_base_sum = r_fwd_hit ? r_fwd_sum : r_rd_sum;
        w_base_sq  = r_fwd_hit ? r_fwd_sq : r_rd_sq;
        if (r1_flags.first_row) begin
            n_sum = w_x_ext;
            n_sq  = r1_sq;
        end else begin
            n_sum = w_base_sum + w_x_ext;
            n_sq  = w_base_sq + r1_sq;
        end
    end

    // read-modify-write: read at accept, write back in the next cycle
    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_rd_sum <= mem_sum[i_addr];
            r_rd_sq  <= mem_sq[i_addr];
        end
        if (r1_valid) begin
            mem_sum[r1_addr] <= n_sum;
            mem_sq[r1_addr]  <= n_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_addr   <= i_addr;
        r1_x      <= i_x;
        r1_sq     <= i_sq;
        r1_flags  <= i_flags;
        r_fwd_sum <= n_sum;
        r_fwd_sq  <= n_sq;
        r2_sum    <= n_sum;
        r2_sq     <= n_sq;
        r2_flags  <= r1_flags;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid  <= 1'b0;
            r_fwd_hit <= 1'b0;
            r2_valid  <= 1'b0;
        end else begin
            r1_valid  <= i_valid;
            r_fwd_hit <= i_valid && r1_valid && (i_addr == r1_addr);
            r2_valid  <= r1_valid;
        end
    end

    assign o_valid = r2_valid;
    assign o_sum   = r2_sum;
    assign o_sq    = r2_sq;
    assign o_flags = r2_flags;

endmodule

### sv/fmpi_out_fifo.sv
module fmpi_out_fifo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic signed [fmpi_pkg::OUT_W-1:0]  i_data,
    output logic [fmpi_pkg::FIFO_AW:0]         o_count,
    fmpi_result_if.source                      o_result
);

    localparam int AW = fmpi_pkg::FIFO_AW;

    logic signed [fmpi_pkg::OUT_W-1:0] r_mem [fmpi_pkg::FIFO_DEPTH];
    logic [AW-1:0] r_wr;
    logic [AW-1:0] r_rd;
    logic [AW:0]   r_count;
    logic          w_pop;

    assign w_pop = o_result.valid && o_result.ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_count <= r_count + {{AW{1'b0}}, i_push} - {{AW{1'b0}}, w_pop};
        end
    end

    assign o_result.valid       = (r_count != '0);
    assign o_result.interaction = r_mem[r_rd];
    assign o_count              = r_count;

endmodule

### sv/fmpi_checker.sv
module fmpi_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               i_in_ready,
    input logic                               i_out_valid,
    input logic                               i_out_ready,
    input logic [fmpi_pkg::OUT_W-1:0]         i_out_interaction
);

    logic [31:0] r_in_cnt;
    logic [31:0] r_out_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cnt  <= '0;
            r_out_cnt <= '0;
        end else begin
            r_in_cnt  <= r_in_cnt + {31'd0, i_in_valid && i_in_ready};
            r_out_cnt <= r_out_cnt + {31'd0, i_out_valid && i_out_ready};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_interaction)))
        else $error("result changed while stalled");

    a_no_extra_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) |-> (r_out_cnt < r_in_cnt))
        else $error("result without a preceding element");

    a_drain_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_out_ready) |-> i_in_ready)
        else $error("input stalled although results drain");

endmodule

bind fm_pairwise_interaction_core fmpi_checker u_fmpi_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_valid        (i_elem.valid),
    .i_in_ready        (i_elem.ready),
    .i_out_valid       (o_result.valid),
    .i_out_ready       (o_result.ready),
    .i_out_interaction (o_result.interaction)
);
